FILE: rtl/pwob_pkg.sv
// Shared types and constants for the price window occupancy book.
// No dependencies; imported by pwob_front, pwob_back and the top level.
package pwob_pkg;

  localparam int WindowLevelsDef = 256;
  localparam int CountBitsDef    = 16;
  localparam int ChunkBits       = 16;  // occupancy bits examined per scan cycle
  localparam int BestBits        = 9;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_ADD  = 2'd1,
    KIND_REM  = 2'd2,
    KIND_MOVE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MV_NONE  = 2'd0,
    MV_CLEAR = 2'd1,
    MV_DOWN  = 2'd2,
    MV_UP    = 2'd3
  } move_e;

  typedef struct packed {
    kind_e op;
    logic  in_win;
    move_e mode;
  } ctl_t;

  // index of the lowest set bit of a chunk (0 when none set)
  function automatic logic [3:0] lowest16(input logic [ChunkBits-1:0] v);
    logic [3:0] r;
    r = '0;
    for (int k = ChunkBits - 1; k >= 0; k--) begin
      if (v[k]) r = 4'(k);
    end
    return r;
  endfunction

endpackage

FILE: rtl/pwob_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pwob_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pwob_fifo.sv
// Two-entry command queue between the front and back parts.
// No dependencies.
module pwob_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] data_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = data_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/pwob_front.sv
// Front part: tracks the window base and classifies each word into a command.
// Depends on pwob_pkg.
module pwob_front import pwob_pkg::*; #(
  parameter int WINDOW_LEVELS = WindowLevelsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [1:0]                       kind_i,
  input  logic [31:0]                      price_i,
  output ctl_t                             ctl_o,
  output logic [$clog2(WINDOW_LEVELS)-1:0] lvl_o,
  output logic [31:0]                      base_o
);

  localparam int IW = $clog2(WINDOW_LEVELS);
  localparam logic [31:0] Half = 32'(WINDOW_LEVELS / 2);
  localparam logic [31:0] Wl32 = 32'(WINDOW_LEVELS);

  logic [31:0] base_q;
  logic [31:0] new_base, idx, delta, neg;
  kind_e       kind;

  assign kind     = kind_e'(kind_i);
  assign new_base = price_i - Half;
  assign idx      = price_i - base_q;
  assign delta    = new_base - base_q;
  assign neg      = 32'd0 - delta;

  always_comb begin
    ctl_o.op     = kind;
    ctl_o.in_win = 1'b0;
    ctl_o.mode   = MV_NONE;
    lvl_o        = '0;
    base_o       = base_q;
    unique case (kind)
      KIND_INIT: begin
        base_o = new_base;
      end
      KIND_ADD, KIND_REM: begin
        ctl_o.in_win = idx < Wl32;
        lvl_o        = idx[IW-1:0];
      end
      KIND_MOVE: begin
        base_o = new_base;
        if (delta == 32'd0) begin
          ctl_o.mode = MV_NONE;
        end else if (!delta[31] && delta < Wl32) begin
          ctl_o.mode = MV_DOWN;  // levels move to lower indexes
          lvl_o      = delta[IW-1:0];
        end else if (delta[31] && neg < Wl32) begin
          ctl_o.mode = MV_UP;
          lvl_o      = neg[IW-1:0];
        end else begin
          ctl_o.mode = MV_CLEAR;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (accept_i && (kind == KIND_INIT || kind == KIND_MOVE)) begin
      base_q <= new_base;
    end
  end

endmodule

FILE: rtl/pwob_back.sv
// Back part: level counts in RAM, occupancy flops, window moves, best-level scan.
// Depends on pwob_pkg and pwob_ram.
module pwob_back import pwob_pkg::*; #(
  parameter int WINDOW_LEVELS = WindowLevelsDef,
  parameter int COUNT_BITS    = CountBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  output logic                             cmd_pop_o,
  input  ctl_t                             ctl_i,
  input  logic [$clog2(WINDOW_LEVELS)-1:0] lvl_i,
  input  logic [31:0]                      base_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [BestBits-1:0]       best_level_o,
  output logic                             in_window_o,
  output logic [31:0]                      window_base_o
);

  localparam int IW  = $clog2(WINDOW_LEVELS);
  localparam int NCH = WINDOW_LEVELS / ChunkBits;
  localparam int CW  = $clog2(NCH);
  localparam logic [IW-1:0] LastIdx = IW'(WINDOW_LEVELS - 1);
  localparam logic [CW-1:0] LastCh  = CW'(NCH - 1);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_UPD  = 6'b000010,
    S_MRD  = 6'b000100,
    S_MWR  = 6'b001000,
    S_SCAN = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  state_e                  state_q, state_d;
  ctl_t                    ctl_q, ctl_d;
  logic [IW-1:0]           lvl_q, lvl_d;
  logic [31:0]             base_q, base_d;
  logic [IW-1:0]           ptr_q, ptr_d;
  logic [CW-1:0]           ch_q, ch_d;
  logic [BestBits-1:0]     best_q, best_d;
  logic [WINDOW_LEVELS-1:0] occ_q, occ_d;

  logic                    out_valid_q;
  logic [BestBits-1:0]     out_best_q;
  logic                    out_in_q;
  logic [31:0]             out_base_q;
  logic                    out_load;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0]   ram_wdata, ram_rdata, cur_cnt;

  logic [ChunkBits-1:0]    chunk;
  logic [IW+BestBits-1:0]  best_wide;
  logic [IW-1:0]           dest_dn, dest;
  logic [IW:0]             up_sum;
  logic                    dest_ok, src_occ, last_ptr;

  pwob_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(WINDOW_LEVELS)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // RAM content is only meaningful where the occupancy bit is set
  assign cur_cnt   = occ_q[lvl_q] ? ram_rdata : '0;
  assign chunk     = occ_q[{ch_q, 4'b0000} +: ChunkBits];
  assign best_wide = {{BestBits{1'b0}}, ch_q, lowest16(chunk)};
  assign dest_dn   = ptr_q - lvl_q;
  assign up_sum    = {1'b0, ptr_q} + {1'b0, lvl_q};
  assign dest      = (ctl_q.mode == MV_DOWN) ? dest_dn : up_sum[IW-1:0];
  assign dest_ok   = (ctl_q.mode == MV_DOWN) ? (ptr_q >= lvl_q) : !up_sum[IW];
  assign src_occ   = occ_q[ptr_q];
  assign last_ptr  = (ctl_q.mode == MV_DOWN) ? (ptr_q == LastIdx) : (ptr_q == '0);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    ctl_d     = ctl_q;
    lvl_d     = lvl_q;
    base_d    = base_q;
    ptr_d     = ptr_q;
    ch_d      = ch_q;
    best_d    = best_q;
    occ_d     = occ_q;
    ram_we    = 1'b0;
    ram_waddr = lvl_q;
    ram_wdata = cur_cnt;
    ram_raddr = lvl_q;
    unique case (state_q)
      S_IDLE: begin
        ram_raddr = lvl_i;
        if (cmd_valid_i) begin
          ctl_d  = ctl_i;
          lvl_d  = lvl_i;
          base_d = base_i;
          ch_d   = '0;
          ptr_d  = (ctl_i.mode == MV_UP) ? LastIdx : '0;
          state_d = S_SCAN;
          case (ctl_i.op)
            KIND_INIT: occ_d = '0;
            KIND_ADD, KIND_REM: begin
              if (ctl_i.in_win) state_d = S_UPD;
            end
            KIND_MOVE: begin
              if (ctl_i.mode == MV_CLEAR) begin
                occ_d = '0;
              end else if (ctl_i.mode != MV_NONE) begin
                state_d = S_MRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_UPD: begin
        ram_waddr = lvl_q;
        if (ctl_q.op == KIND_ADD) begin
          ram_we    = 1'b1;
          ram_wdata = (cur_cnt == CountMax) ? cur_cnt : cur_cnt + CountOne;
          occ_d[lvl_q] = 1'b1;
        end else if (cur_cnt != '0) begin
          ram_we    = 1'b1;
          ram_wdata = cur_cnt - CountOne;
          if (cur_cnt == CountOne) occ_d[lvl_q] = 1'b0;
        end
        state_d = S_SCAN;
      end
      S_MRD: begin
        ram_raddr = ptr_q;
        state_d   = S_MWR;
      end
      S_MWR: begin
        // source slot is emptied first; a later source may refill it
        occ_d[ptr_q] = 1'b0;
        if (dest_ok) occ_d[dest] = src_occ;
        ram_we    = dest_ok && src_occ;
        ram_waddr = dest;
        ram_wdata = ram_rdata;
        if (last_ptr) begin
          state_d = S_SCAN;
        end else begin
          ptr_d   = (ctl_q.mode == MV_DOWN) ? ptr_q + IW'(1) : ptr_q - IW'(1);
          state_d = S_MRD;
        end
      end
      S_SCAN: begin
        if (chunk != '0) begin
          best_d  = best_wide[BestBits-1:0];
          state_d = S_DONE;
        end else if (ch_q == LastCh) begin
          best_d  = '1;
          state_d = S_DONE;
        end else begin
          ch_d = ch_q + CW'(1);
        end
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q  <= ctl_d;
    lvl_q  <= lvl_d;
    base_q <= base_d;
    ptr_q  <= ptr_d;
    ch_q   <= ch_d;
    best_q <= best_d;
    if (out_load) begin
      out_best_q <= best_q;
      out_in_q   <= ctl_q.in_win;
      out_base_q <= base_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_level_o  = out_best_q;
  assign in_window_o   = out_in_q;
  assign window_base_o = out_base_q;

  a_upd_after_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> $past(state_q) == S_IDLE)
    else $error("count update not preceded by command pop");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("finished result not loaded into free output register");

  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_UPD || state_q == S_MWR))
    else $error("count RAM written outside update or move");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != S_IDLE))
    else $error("popped command not started");

endmodule

FILE: rtl/price_window_occupancy_book.sv
// Top level of the price window occupancy book: front, command queue, back.
// Depends on pwob_pkg, pwob_front, pwob_fifo, pwob_back.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o | kind_i, price_i
//  out     | out_valid_o/out_stall_i | best_level_o, in_window_o, window_base_o
//
// Initialise clears the occupancy flops and then scans; add/remove in the window
// first does the count read-modify-write through the single-port-write RAM.
// Recentre by a shift inside the window walks every level, then scans.
// The best-level scan looks at 16 levels per cycle.
// Reset clears the occupancy flops at once; no clearing pass is needed.
// A two-entry queue lets the input keep accepting while the back end works, until it is full.
module price_window_occupancy_book import pwob_pkg::*; #(
  parameter int WINDOW_LEVELS = WindowLevelsDef,
  parameter int COUNT_BITS    = CountBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 kind_i,
  input  logic [31:0]                price_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [BestBits-1:0] best_level_o,
  output logic                       in_window_o,
  output logic [31:0]                window_base_o
);

  localparam int IW = $clog2(WINDOW_LEVELS);
  localparam int QW = $bits(ctl_t) + IW + 32;

  logic          accept, full, q_valid, pop;
  ctl_t          f_ctl, b_ctl;
  logic [IW-1:0] f_lvl, b_lvl;
  logic [31:0]   f_base, b_base;
  logic [QW-1:0] q_wdata, q_rdata;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  pwob_front #(
    .WINDOW_LEVELS(WINDOW_LEVELS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .kind_i  (kind_i),
    .price_i (price_i),
    .ctl_o   (f_ctl),
    .lvl_o   (f_lvl),
    .base_o  (f_base)
  );

  assign q_wdata = {f_ctl, f_lvl, f_base};

  pwob_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .wdata_i(q_wdata),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .rdata_o(q_rdata)
  );

  assign {b_ctl, b_lvl, b_base} = q_rdata;

  pwob_back #(
    .WINDOW_LEVELS(WINDOW_LEVELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_pop_o    (pop),
    .ctl_i        (b_ctl),
    .lvl_i        (b_lvl),
    .base_i       (b_base),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .best_level_o (best_level_o),
    .in_window_o  (in_window_o),
    .window_base_o(window_base_o)
  );

endmodule
